@@ hw/rtl/dtq_pkg.sv @@
// Deadline timer queue package: status codes, field widths and result limit.
// No dependencies; imported by the top level and its checker.
package dtq_pkg;

   localparam int HANDLE_W   = 16;
   localparam int WAIT_W     = 16;
   localparam int TIME_W     = 32;
   localparam int DEADLINE_W = 33;
   localparam int STATUS_W   = 2;

   localparam int MAX_RESULTS = 16;
   localparam int EMIT_W      = $clog2(MAX_RESULTS);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POLL   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUE      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE = 2'd3;

endpackage

@@ hw/rtl/deadline_timer_queue.sv @@
// Deadline timer queue: insert gives one response in the cycle after the request.
// A poll scans the slot memory once per due task, up to MAX_RESULTS responses:
// each due response takes one memory read per slot, then the emit step, and a
// poll with nothing due gives a single response after its scan.
// busy stays high until the last response of a poll; the receiver cannot stall.
// Reset clears the valid bits at once; the slot memory needs no clearing pass.
module deadline_timer_queue
   import dtq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [HANDLE_W-1:0]   req_task_handle,
   input  logic [WAIT_W-1:0]     req_wait_ticks,
   input  logic [TIME_W-1:0]     req_current_time,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [HANDLE_W-1:0]   rsp_due_handle,
   output logic [DEADLINE_W-1:0] rsp_due_deadline,
   output logic                  rsp_last
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WORD_W = HANDLE_W + DEADLINE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   // slot memory: {handle, deadline}
   logic [WORD_W-1:0] slot_mem [CAPACITY];
   logic [WORD_W-1:0] mem_rd_ff;

   state_type             state_ff, state_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [DEADLINE_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  issue_ff, issue_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [DEADLINE_W-1:0] best_dl_ff, best_dl_in;
   logic [HANDLE_W-1:0]   best_hdl_ff, best_hdl_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [EMIT_W-1:0]     emit_ff, emit_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [DEADLINE_W-1:0] rsp_dl_ff, rsp_dl_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic                  wr_en;
   logic [DEADLINE_W-1:0] new_dl;
   logic [HANDLE_W-1:0]   rd_hdl;
   logic [DEADLINE_W-1:0] rd_dl;
   logic                  rd_due;
   logic                  emit_last;

   assign accept = start && (state_ff == S_IDLE);
   assign new_dl = DEADLINE_W'(req_current_time) + DEADLINE_W'(req_wait_ticks);
   assign wr_en  = accept && (req_operation == OP_INSERT) && free_found;
   assign rd_hdl = mem_rd_ff[WORD_W-1 -: HANDLE_W];
   assign rd_dl  = mem_rd_ff[DEADLINE_W-1:0];
   assign rd_due = rd_pend_ff && valid_ff[rd_idx_ff] && (rd_dl <= now_ff);
   assign emit_last = (count_ff == CNT_W'(1)) || (emit_ff == EMIT_W'(MAX_RESULTS - 1));

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // hold read data in a register behind the scan address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[free_idx] <= {req_task_handle, new_dl};
      end
      mem_rd_ff <= slot_mem[scan_idx_ff];
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      now_in        = now_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      rd_pend_in    = (state_ff == S_SCAN) && issue_ff;
      rd_idx_in     = scan_idx_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_hdl_in   = best_hdl_ff;
      count_in      = count_ff;
      emit_in       = emit_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_dl_in     = rsp_dl_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_operation == OP_INSERT) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = free_found ? ST_INSERTED : ST_FULL;
                  rsp_handle_in = '0;
                  rsp_dl_in     = '0;
                  rsp_last_in   = 1'b1;
                  if (free_found) begin
                     valid_in[free_idx] = 1'b1;
                  end
               end else begin
                  state_in    = S_SCAN;
                  now_in      = DEADLINE_W'(req_current_time);
                  scan_idx_in = '0;
                  issue_in    = 1'b1;
                  best_vld_in = 1'b0;
                  count_in    = '0;
                  emit_in     = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               if (scan_idx_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
            if (rd_due) begin
               count_in = count_ff + 1'b1;
               if (!best_vld_ff || (rd_dl < best_dl_ff)) begin
                  best_vld_in = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_dl_in  = rd_dl;
                  best_hdl_in = rd_hdl;
               end
            end
            if (rd_pend_ff && (rd_idx_ff == LAST_IDX)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            if (count_ff == '0) begin
               rsp_status_in = ST_NONE_DUE;
               rsp_handle_in = '0;
               rsp_dl_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rsp_status_in         = ST_DUE;
               rsp_handle_in         = best_hdl_ff;
               rsp_dl_in             = best_dl_ff;
               rsp_last_in           = emit_last;
               valid_in[best_idx_ff] = 1'b0;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  state_in    = S_SCAN;
                  emit_in     = emit_ff + 1'b1;
                  scan_idx_in = '0;
                  issue_in    = 1'b1;
                  best_vld_in = 1'b0;
                  count_in    = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         issue_ff      <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         issue_ff      <= issue_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      now_ff        <= now_in;
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      best_vld_ff   <= best_vld_in;
      best_idx_ff   <= best_idx_in;
      best_dl_ff    <= best_dl_in;
      best_hdl_ff   <= best_hdl_in;
      count_ff      <= count_in;
      emit_ff       <= emit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_dl_ff     <= rsp_dl_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_due_handle   = rsp_handle_ff;
   assign rsp_due_deadline = rsp_dl_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

@@ hw/rtl/dtq_checker.sv @@
// Port-level checker for the deadline timer queue, with its bind statement.
// Depends on dtq_pkg and on the deadline_timer_queue ports.
module dtq_checker
   import dtq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_operation,
   input logic                  rsp_strobe,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [HANDLE_W-1:0]   rsp_due_handle,
   input logic [DEADLINE_W-1:0] rsp_due_deadline,
   input logic                  rsp_last
);

   a_insert_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_INSERT)) |=>
         (rsp_strobe && rsp_last && !busy &&
          ((rsp_status == ST_INSERTED) || (rsp_status == ST_FULL))))
      else $error("insert request did not give one final response");

   a_poll_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_POLL)) |=> (busy && !rsp_strobe))
      else $error("poll request did not hold busy");

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (busy && (rsp_status == ST_DUE)))
      else $error("non-final response outside a poll");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_DUE)) |->
         ((rsp_due_handle == '0) && (rsp_due_deadline == '0) && rsp_last))
      else $error("non-due response carries task fields");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("busy held after final response");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_operation    (req_operation),
   .rsp_strobe       (rsp_strobe),
   .rsp_status       (rsp_status),
   .rsp_due_handle   (rsp_due_handle),
   .rsp_due_deadline (rsp_due_deadline),
   .rsp_last         (rsp_last)
);
